[src/mesh_receive_filter_dedup_assert.svh]
// Assertion macros for the mesh receive filter.
`ifndef MESH_RECEIVE_FILTER_DEDUP_ASSERT_SVH
`define MESH_RECEIVE_FILTER_DEDUP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define MRFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/mrfd_pkg.sv]
// Types and constants shared by the mesh receive filter modules.
package mrfd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned ID_W = 8;
  localparam int unsigned PID_W = 3;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    ACT_DUPLICATE = 3'd0,
    ACT_HOP_DROP  = 3'd1,
    ACT_FORWARD   = 3'd2,
    ACT_ACK       = 3'd3,
    ACT_DATA      = 3'd4,
    ACT_REQUEST   = 3'd5,
    ACT_UNKNOWN   = 3'd6
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID       = 3'd0,
    CFG_TIMEOUT      = 3'd1,
    CFG_TYPE_ACK     = 3'd2,
    CFG_TYPE_DATA    = 3'd3,
    CFG_TYPE_REQUEST = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [ID_W-1:0]   recipient;
    logic [ID_W-1:0]   sender;
    logic [7:0]        msg_type;
    logic [1:0]        priority_req;
    logic [PID_W-1:0]  pkt_seq;
    logic              encrypted;
    logic [1:0]        hop_count;
  } in_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] dest_id;
    logic [7:0] out_flags;
  } out_t;

  // Signals rippling from one cache cell to the next.
  typedef struct packed {
    logic hit;        // a live matching entry was found at or before this cell
    logic free_seen;  // a free slot exists at or before this cell
  } chain_t;

endpackage

[src/mrfd_cell.sv]
// One cache slot: expiry check, match, refresh and store of a (sender, id) pair.
module mrfd_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            upd,
  input  logic [mrfd_pkg::TIME_W-1:0]     now_ms,
  input  logic [mrfd_pkg::ID_W-1:0]       sender,
  input  logic [mrfd_pkg::PID_W-1:0]      pkt_seq,
  input  logic [mrfd_pkg::TIMEOUT_W-1:0]  timeout,
  input  logic                            hit_total,
  input  mrfd_pkg::chain_t                chain_in,
  output mrfd_pkg::chain_t                chain_out,
  output logic                            store
);
  import mrfd_pkg::*;

  logic              valid;
  logic [ID_W-1:0]   entry_sender;
  logic [PID_W-1:0]  entry_packet;
  logic [TIME_W-1:0] entry_time;
  logic [TIME_W-1:0] age;
  logic              live;
  logic              match;

  assign age   = now_ms - entry_time;
  assign live  = valid && (age <= {{(TIME_W-TIMEOUT_W){1'b0}}, timeout});
  assign match = live && (entry_sender == sender) && (entry_packet == pkt_seq);

  assign chain_out.hit       = chain_in.hit | match;
  assign chain_out.free_seen = chain_in.free_seen | !live;

  // Only the lowest free slot takes a new pair, and only when no slot hit.
  assign store = !live && !chain_in.free_seen && !hit_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd) begin
      valid <= live | store;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      if (store) begin
        entry_sender <= sender;
        entry_packet <= pkt_seq;
        entry_time   <= now_ms;
      end else if (match && !chain_in.hit) begin
        entry_time <= now_ms;
      end
    end
  end

endmodule

[src/mrfd_out_skid.sv]
// Output register with a skid stage so the input side waits on the output stall only once the skid stage is full.
module mrfd_out_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrfd_pkg::out_t push_data,
  input  logic           out_stall,
  output logic           full,
  output logic           out_valid,
  output mrfd_pkg::out_t out_data
);
  import mrfd_pkg::*;

  logic skid_valid;
  out_t skid_data;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[src/mesh_receive_filter_dedup.sv]
// Mesh receive filter: duplicate suppression cache and packet classification.
// Each result is registered at the accept edge, into the skid stage while the output is held.
// Throughput: one header per cycle while in_stall is low; the cache cells update at the accept edge,
// and the compare/claim chain through all cells resolves within that cycle.
// Reset: all cache slots invalid; registers return to own_id 1, timeout 500,
// type codes acknowledge 0, data 1, request 2; both output stages empty.
module mesh_receive_filter_dedup #(
  parameter int unsigned CACHE_ENTRIES = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mrfd_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mrfd_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mrfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mrfd_pkg::*;
  `include "mesh_receive_filter_dedup_assert.svh"

  logic [ID_W-1:0]      own_id;
  logic [TIMEOUT_W-1:0] cache_timeout_ms;
  logic [7:0]           type_acknowledge;
  logic [7:0]           type_data;
  logic [7:0]           type_request;

  logic                     accept;
  logic                     hit_total;
  chain_t                   chain [CACHE_ENTRIES+1];
  logic [CACHE_ENTRIES-1:0] store_vec;
  out_t                     result;
  logic                     skid_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id           <= 8'd1;
      cache_timeout_ms <= 16'd500;
      type_acknowledge <= 8'd0;
      type_data        <= 8'd1;
      type_request     <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OWN_ID:       own_id           <= cfg_data[ID_W-1:0];
        CFG_TIMEOUT:      cache_timeout_ms <= cfg_data;
        CFG_TYPE_ACK:     type_acknowledge <= cfg_data[7:0];
        CFG_TYPE_DATA:    type_data        <= cfg_data[7:0];
        CFG_TYPE_REQUEST: type_request     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_full;
  assign accept   = in_valid && !in_stall;

  assign chain[0].hit       = 1'b0;
  assign chain[0].free_seen = 1'b0;
  assign hit_total          = chain[CACHE_ENTRIES].hit;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    mrfd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .upd       (accept),
      .now_ms    (in_data.now_ms),
      .sender    (in_data.sender),
      .pkt_seq   (in_data.pkt_seq),
      .timeout   (cache_timeout_ms),
      .hit_total (hit_total),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .store     (store_vec[i])
    );
  end

  always_comb begin
    result.action    = ACT_UNKNOWN;
    result.dest_id   = 8'd0;
    result.out_flags = 8'd0;
    if (hit_total) begin
      result.action = ACT_DUPLICATE;
    end else if ((in_data.recipient != own_id) && (in_data.recipient != 8'd0)) begin
      if (in_data.hop_count == 2'd0) begin
        result.action = ACT_HOP_DROP;
      end else begin
        result.action    = ACT_FORWARD;
        result.dest_id   = in_data.recipient;
        result.out_flags = {in_data.priority_req, in_data.pkt_seq, in_data.encrypted,
                            2'(in_data.hop_count - 2'd1)};
      end
    end else if (in_data.msg_type == type_acknowledge) begin
      result.action = ACT_ACK;
    end else if (in_data.msg_type == type_data) begin
      result.action = ACT_DATA;
    end else if (in_data.msg_type == type_request) begin
      result.action  = ACT_REQUEST;
      result.dest_id = in_data.sender;
    end
  end

  mrfd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .out_stall (out_stall),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // At most one slot claims a new pair, and none does when the pair hit.
  `MRFD_ASSERT_NOW(a_single_store, clk, rst, accept, $onehot0(store_vec))
  `MRFD_ASSERT_NOW(a_no_store_on_hit, clk, rst, accept && hit_total, store_vec == '0)
  // The skid stage fills only behind a held output.
  `MRFD_ASSERT_NOW(a_skid_behind_out, clk, rst, in_stall, out_valid)
  `MRFD_ASSERT_NEXT(a_dup_result, clk, rst, accept && hit_total && !in_stall && !out_valid, out_valid && out_data.action == ACT_DUPLICATE && out_data.dest_id == 8'd0)

endmodule

[test/mrfd_checker.sv]
`timescale 1ns / 1ps
// Checker for the mesh receive filter: predicts every result from observed transactions.
module mrfd_checker #(
  parameter int unsigned CACHE_ENTRIES = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  mrfd_pkg::in_t                     in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  mrfd_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [mrfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                mismatches,
  output int                                pending
);
  import mrfd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [7:0]  node_id;
  logic [15:0] age_limit;
  logic [7:0]  code_ack;
  logic [7:0]  code_data;
  logic [7:0]  code_req;

  logic        seen_valid  [CACHE_ENTRIES];
  logic [7:0]  seen_sender [CACHE_ENTRIES];
  logic [2:0]  seen_pid    [CACHE_ENTRIES];
  logic [31:0] seen_ms     [CACHE_ENTRIES];

  out_t expected_q[$];

  // Runs one header through the duplicate cache and classifies it.
  function automatic out_t filter_packet(input in_t hdr);
    out_t        res;
    logic        hit;
    logic        stored;
    logic [31:0] age;
    res.action    = ACT_DUPLICATE;
    res.dest_id   = 8'd0;
    res.out_flags = 8'd0;
    hit    = 1'b0;
    stored = 1'b0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      age = hdr.now_ms - seen_ms[i];
      if (seen_valid[i] && age > {16'd0, age_limit}) seen_valid[i] = 1'b0;
    end
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (!hit && seen_valid[i] && seen_sender[i] == hdr.sender &&
          seen_pid[i] == hdr.pkt_seq) begin
        seen_ms[i] = hdr.now_ms;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (!stored && !seen_valid[i]) begin
          seen_valid[i]  = 1'b1;
          seen_sender[i] = hdr.sender;
          seen_pid[i]    = hdr.pkt_seq;
          seen_ms[i]     = hdr.now_ms;
          stored = 1'b1;
        end
      end
    end
    if (hit) begin
      res.action = ACT_DUPLICATE;
    end else if (hdr.recipient != node_id && hdr.recipient != 8'd0) begin
      if (hdr.hop_count == 2'd0) begin
        res.action = ACT_HOP_DROP;
      end else begin
        res.action    = ACT_FORWARD;
        res.dest_id   = hdr.recipient;
        res.out_flags = {hdr.priority_req, hdr.pkt_seq, hdr.encrypted,
                         2'(hdr.hop_count - 2'd1)};
      end
    end else if (hdr.msg_type == code_ack) begin
      res.action = ACT_ACK;
    end else if (hdr.msg_type == code_data) begin
      res.action = ACT_DATA;
    end else if (hdr.msg_type == code_req) begin
      res.action  = ACT_REQUEST;
      res.dest_id = hdr.sender;
    end else begin
      res.action = ACT_UNKNOWN;
    end
    return res;
  endfunction

  task automatic log_mismatch(input logic have_want, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      if (have_want) begin
        $display("%0t: mismatch: expected action %0d dest %0d flags 0x%02h,",
                 $realtime, want.action, want.dest_id, want.out_flags,
                 " got action %0d dest %0d flags 0x%02h",
                 got.action, got.dest_id, got.out_flags);
      end else begin
        $display("%0t: unexpected result: action %0d dest %0d flags 0x%02h",
                 $realtime, got.action, got.dest_id, got.out_flags);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      // Register values after reset.
      node_id    = 8'd1;
      age_limit  = 16'd500;
      code_ack   = 8'd0;
      code_data  = 8'd1;
      code_req   = 8'd2;
      mismatches = 0;
      for (int i = 0; i < CACHE_ENTRIES; i++) seen_valid[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_ID:       node_id   = cfg_data[7:0];
          CFG_TIMEOUT:      age_limit = cfg_data[15:0];
          CFG_TYPE_ACK:     code_ack  = cfg_data[7:0];
          CFG_TYPE_DATA:    code_data = cfg_data[7:0];
          CFG_TYPE_REQUEST: code_req  = cfg_data[7:0];
          default: ;
        endcase
      end
      // Compare before pushing: a result never belongs to a header accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          want = '0;
          log_mismatch(1'b0, want, out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data.action !== want.action || out_data.dest_id !== want.dest_id ||
              out_data.out_flags !== want.out_flags) begin
            log_mismatch(1'b1, want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(filter_packet(in_data));
    end
    pending = expected_q.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the mesh receive filter: stimulus, flow control and verdict.
module tb;
  import mrfd_pkg::*;

  localparam int unsigned CACHE_ENTRIES = 4;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 82;
  localparam int unsigned HOLD_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          mismatches;
  int          pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned holds_req     = 0;
  int unsigned cycles        = 0;

  // Stimulus-side copy of the settings, used to program the block and to shape headers.
  logic [31:0] clock_ms;
  logic [7:0]  own_cfg;
  logic [15:0] timeout_cfg;
  logic [7:0]  ack_cfg;
  logic [7:0]  data_cfg;
  logic [7:0]  req_cfg;
  logic [7:0]  sender_pool [3];

  mesh_receive_filter_dedup #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mrfd_checker #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("mesh_receive_filter_dedup verification failed");
      $finish;
    end
  end

  // Output flow control; a requested hold keeps the output stalled for a long stretch.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_done != holds_req) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_t make_hdr(input logic [31:0] ms, input logic [7:0] rcpt,
                                   input logic [7:0] snd, input logic [7:0] mtype,
                                   input logic [1:0] prio, input logic [2:0] pid,
                                   input logic en, input logic [1:0] hops);
    in_t h;
    h.now_ms       = ms;
    h.recipient    = rcpt;
    h.sender       = snd;
    h.msg_type     = mtype;
    h.priority_req = prio;
    h.pkt_seq      = pid;
    h.encrypted    = en;
    h.hop_count    = hops;
    return h;
  endfunction

  // Mostly a steadily advancing clock over a few senders, so that entries hit, age out
  // at the timeout edge and fill the cache; now and then a wild jump or a step back.
  function automatic in_t random_hdr();
    in_t         h;
    int unsigned pick;
    int unsigned lim;
    lim  = timeout_cfg;
    pick = $urandom_range(99);
    if (pick < 25)      clock_ms = clock_ms;
    else if (pick < 60) clock_ms = clock_ms + $urandom_range(lim / 3 + 1, 1);
    else if (pick < 70) clock_ms = clock_ms + lim;
    else if (pick < 78) clock_ms = clock_ms + lim + 1;
    else if (pick < 94) clock_ms = clock_ms + $urandom_range(2 * lim + 2, 1);
    else if (pick < 98) clock_ms = clock_ms + $urandom();
    else                clock_ms = clock_ms - $urandom_range(100, 1);
    h.now_ms = clock_ms;
    pick = $urandom_range(9);
    if (pick < 3)      h.recipient = own_cfg;
    else if (pick < 5) h.recipient = 8'd0;
    else               h.recipient = 8'($urandom_range(255));
    if ($urandom_range(99) < 85) h.sender = sender_pool[$urandom_range(2)];
    else                         h.sender = 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       h.msg_type = ack_cfg;
      1:       h.msg_type = data_cfg;
      2:       h.msg_type = req_cfg;
      default: h.msg_type = 8'($urandom_range(255));
    endcase
    if ($urandom_range(99) < 70) h.pkt_seq = 3'($urandom_range(1));
    else                         h.pkt_seq = 3'($urandom_range(7));
    h.priority_req = 2'($urandom_range(3));
    h.encrypted    = 1'($urandom_range(1));
    h.hop_count    = 2'($urandom_range(3));
    return h;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance, valid still high.
  task automatic offer_header(input in_t hdr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= hdr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Upper data bits of the byte-wide registers carry noise, which the block discards.
  task automatic apply_config(input logic junk_write);
    if (junk_write) begin
      cfg_write(CFG_TYPE_REQUEST + 3'($urandom_range(3, 1)), 16'($urandom_range(65535)));
    end
    cfg_write(CFG_OWN_ID,       {8'($urandom_range(255)), own_cfg});
    cfg_write(CFG_TIMEOUT,      timeout_cfg);
    cfg_write(CFG_TYPE_ACK,     {8'($urandom_range(255)), ack_cfg});
    cfg_write(CFG_TYPE_DATA,    {8'($urandom_range(255)), data_cfg});
    cfg_write(CFG_TYPE_REQUEST, {8'($urandom_range(255)), req_cfg});
    cfg_valid <= 1'b0;
  endtask

  // Waits at falling edges until every expected result has arrived, plus a short margin.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] t0;
    own_cfg     = 8'd1;
    timeout_cfg = 16'd500;
    ack_cfg     = 8'd0;
    data_cfg    = 8'd1;
    req_cfg     = 8'd2;
    t0          = 32'hFFFF_FF00;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed headers at the reset settings; the clock wraps through zero on the way.
    offer_header(make_hdr(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 3'd7, 1'b1, 2'd3));
    offer_header(make_hdr(32'd0, 8'd0, 8'd0, 8'd0, 2'd0, 3'd0, 1'b0, 2'd0));
    offer_header(make_hdr(t0, own_cfg, 8'd5, ack_cfg, 2'd0, 3'd0, 1'b0, 2'd0));
    offer_header(make_hdr(t0, own_cfg, 8'd5, ack_cfg, 2'd0, 3'd0, 1'b0, 2'd0));
    offer_header(make_hdr(t0, 8'd0, 8'd6, data_cfg, 2'd1, 3'd7, 1'b0, 2'd1));
    offer_header(make_hdr(t0, own_cfg, 8'd7, req_cfg, 2'd2, 3'd2, 1'b1, 2'd2));
    offer_header(make_hdr(t0, own_cfg, 8'd8, 8'hFF, 2'd0, 3'd3, 1'b0, 2'd0));
    // The cache is full now: these misses are classified but not stored.
    offer_header(make_hdr(t0, 8'h33, 8'd9, data_cfg, 2'd0, 3'd5, 1'b0, 2'd0));
    offer_header(make_hdr(t0, 8'hC4, 8'd9, data_cfg, 2'd3, 3'd5, 1'b1, 2'd3));
    offer_header(make_hdr(t0, 8'h80, 8'd10, ack_cfg, 2'd2, 3'd6, 1'b0, 2'd1));
    // Exactly at the timeout the entry survives; one past it, it is gone.
    offer_header(make_hdr(t0 + 32'd500, own_cfg, 8'd5, data_cfg, 2'd0, 3'd0, 1'b0, 2'd0));
    offer_header(make_hdr(t0 + 32'd1001, own_cfg, 8'd5, req_cfg, 2'd1, 3'd0, 1'b0, 2'd1));
    offer_header(make_hdr(t0 + 32'd1001, 8'd2, own_cfg, data_cfg, 2'd1, 3'd1, 1'b0, 2'd2));
    offer_header(make_hdr(t0 + 32'd1001, 8'd2, own_cfg, data_cfg, 2'd1, 3'd1, 1'b0, 2'd2));
    offer_header(make_hdr(t0 + 32'd1001, 8'd0, 8'd3, 8'h77, 2'd0, 3'd4, 1'b1, 2'd0));
    offer_header(make_hdr(t0 + 32'd1001, own_cfg, 8'd4, ack_cfg, 2'd0, 3'd2, 1'b0, 2'd1));
    offer_header(make_hdr(t0 + 32'd1001, own_cfg, 8'd5, ack_cfg, 2'd0, 3'd0, 1'b0, 2'd0));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_valid <= 1'b0;
      settle();
      case (ph)
        0: begin
          own_cfg = 8'hFF; timeout_cfg = 16'd0;
          ack_cfg = 8'hFF; data_cfg = 8'h00; req_cfg = 8'h80;
        end
        1: begin
          own_cfg = 8'h00; timeout_cfg = 16'hFFFF;
          ack_cfg = 8'h5A; data_cfg = 8'h5A; req_cfg = 8'h5A;
        end
        3: begin
          own_cfg = 8'($urandom_range(255)); timeout_cfg = 16'd1;
          ack_cfg = 8'($urandom_range(255)); data_cfg = 8'($urandom_range(255));
          req_cfg = ack_cfg;
        end
        default: begin
          own_cfg = 8'($urandom_range(255)); timeout_cfg = 16'($urandom_range(3000, 2));
          ack_cfg = 8'($urandom_range(255)); data_cfg = 8'($urandom_range(255));
          req_cfg = 8'($urandom_range(255));
        end
      endcase
      apply_config(ph == 2);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 77; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 77; end
        default: begin send_idle_pct = 14; stall_pct <= 14; end
      endcase
      for (int k = 0; k < 3; k++) sender_pool[k] = 8'($urandom_range(255));
      clock_ms = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // With no sender gaps, a long output hold backs the block up into its input.
        if (ph % 4 == 0 && n == 10) holds_req <= holds_req + 1;
        offer_header(random_hdr());
      end
    end

    in_valid <= 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("mesh_receive_filter_dedup verification clean");
    end else begin
      $display("mesh_receive_filter_dedup verification failed");
    end
    $finish;
  end

endmodule
